/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the request queue, the engine and the top.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] REG_TICKS_PER_UNIT    = 2'd0;
  localparam logic [1:0] REG_START_STOP_UNITS  = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT_UNITS = 2'd2;

  localparam logic [15:0] TICKS_PER_UNIT_RESET    = 16'd100;
  localparam logic [3:0]  START_STOP_UNITS_RESET  = 4'd4;
  localparam logic [7:0]  ACK_TIMEOUT_UNITS_RESET = 8'd50;

  typedef enum logic [4:0] {
    CMD_NONE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_STOP  = 5'b00100,
    CMD_WRITE = 5'b01000,
    CMD_READ  = 5'b10000
  } cmd_kind_t;

  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_ST_A     = 14'b00000000000010,
    PH_ST_B     = 14'b00000000000100,
    PH_SP_A     = 14'b00000000001000,
    PH_SP_B     = 14'b00000000010000,
    PH_WR_SETUP = 14'b00000000100000,
    PH_WR_HIGH  = 14'b00000001000000,
    PH_WR_LOW   = 14'b00000010000000,
    PH_WA_REL   = 14'b00000100000000,
    PH_WA_POLL  = 14'b00001000000000,
    PH_RD_LOW   = 14'b00010000000000,
    PH_RD_HIGH  = 14'b00100000000000,
    PH_AK_SETUP = 14'b01000000000000,
    PH_AK_HIGH  = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
    logic       command_rejected;
  } res_t;

  typedef struct packed {
    logic [15:0] ticks_per_unit;
    logic [3:0]  start_stop_units;
    logic [7:0]  ack_timeout_units;
  } cfg_t;

endpackage

/* rtl/i2cm_fifo.sv */
// ----------------------------------------------------------------------------
// I2C master small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
  parameter int DEPTH = 2,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output item_t pop_data,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/i2cm_front.sv */
// ----------------------------------------------------------------------------
// I2C master request front end
// Accepts requests, decodes the opcode into a command kind and queues them.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      opcode,
  input  logic [7:0]      tx_byte,
  input  logic            send_ack,
  input  logic            sda_sample,
  input  logic            req_pop,
  output i2cm_pkg::req_t  req,
  output logic            req_empty
);

  i2cm_pkg::req_t decoded;

  always_comb begin
    decoded.tx_byte    = tx_byte;
    decoded.send_ack   = send_ack;
    decoded.sda_sample = sda_sample;
    unique case (opcode)
      i2cm_pkg::OP_START: decoded.kind = i2cm_pkg::CMD_START;
      i2cm_pkg::OP_STOP:  decoded.kind = i2cm_pkg::CMD_STOP;
      i2cm_pkg::OP_WRITE: decoded.kind = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::OP_READ:  decoded.kind = i2cm_pkg::CMD_READ;
      default:            decoded.kind = i2cm_pkg::CMD_NONE;
    endcase
  end

  i2cm_fifo #(
    .DEPTH  (DEPTH),
    .item_t (i2cm_pkg::req_t)
  ) u_req_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (decoded),
    .full      (full),
    .pop       (req_pop),
    .pop_data  (req),
    .empty     (req_empty)
  );

endmodule

/* rtl/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// I2C master bus engine
// Runs the start, stop, write and read sequences one tick per request.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic           clk,
  input  logic           rst,
  input  i2cm_pkg::cfg_t cfg,
  input  i2cm_pkg::req_t req,
  input  logic           req_empty,
  output logic           req_pop,
  output logic           res_push,
  output i2cm_pkg::res_t res,
  input  logic           res_full
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  unit_count, unit_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        sda_oe_reg, sda_oe_reg_next;
  logic        ack_bit, ack_bit_next;
  logic        fail_flag, fail_flag_next;
  logic [7:0]  rx_reg, rx_reg_next;
  logic        done, rejected;

  logic        step;
  logic [15:0] tpu_eff;
  logic [3:0]  ssu_eff;
  logic [15:0] tick_inc;
  logic        unit_tick;
  logic [7:0]  unit_inc;
  logic        hold_done;
  logic [3:0]  bit_inc;
  logic [7:0]  tx_shift;

  assign step     = !req_empty && !res_full;
  assign req_pop  = step;
  assign res_push = step;

  assign tpu_eff   = (cfg.ticks_per_unit == '0) ? 16'd1 : cfg.ticks_per_unit;
  assign ssu_eff   = (cfg.start_stop_units == '0) ? 4'd1 : cfg.start_stop_units;
  assign tick_inc  = tick_count + 16'd1;
  assign unit_tick = (tick_inc >= tpu_eff);
  assign unit_inc  = unit_count + 8'd1;
  assign hold_done = unit_tick && (unit_inc >= {4'd0, ssu_eff});
  assign bit_inc   = bit_count + 4'd1;
  assign tx_shift  = shift_byte << bit_inc[2:0];

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    tick_count_next = tick_count;
    unit_count_next = unit_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_oe_reg_next = sda_oe_reg;
    ack_bit_next    = ack_bit;
    fail_flag_next  = fail_flag;
    rx_reg_next     = rx_reg;
    done            = 1'b0;
    rejected        = 1'b0;

    if (phase == i2cm_pkg::PH_IDLE) begin
      tick_count_next = '0;
      unit_count_next = '0;
      unique case (req.kind)
        i2cm_pkg::CMD_START: begin
          sda_oe_reg_next = 1'b1;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b1;
          phase_next      = i2cm_pkg::PH_ST_A;
        end
        i2cm_pkg::CMD_STOP: begin
          sda_oe_reg_next = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b0;
          phase_next      = i2cm_pkg::PH_SP_A;
        end
        i2cm_pkg::CMD_WRITE: begin
          shift_byte_next = req.tx_byte;
          bit_count_next  = '0;
          fail_flag_next  = 1'b0;
          sda_oe_reg_next = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = req.tx_byte[7];
          phase_next      = i2cm_pkg::PH_WR_SETUP;
        end
        i2cm_pkg::CMD_READ: begin
          shift_byte_next = '0;
          bit_count_next  = '0;
          ack_bit_next    = req.send_ack;
          sda_oe_reg_next = 1'b0;
          scl_reg_next    = 1'b0;
          phase_next      = i2cm_pkg::PH_RD_LOW;
        end
        default: begin
        end
      endcase
    end else begin
      rejected        = (req.kind != i2cm_pkg::CMD_NONE);
      tick_count_next = unit_tick ? 16'd0 : tick_inc;
      unique case (phase)
        i2cm_pkg::PH_ST_A, i2cm_pkg::PH_ST_B,
        i2cm_pkg::PH_SP_A, i2cm_pkg::PH_SP_B: begin
          if (unit_tick) begin
            unit_count_next = hold_done ? 8'd0 : unit_inc;
          end
          if (hold_done) begin
            unique case (phase)
              i2cm_pkg::PH_ST_A: begin
                sda_reg_next = 1'b0;
                phase_next   = i2cm_pkg::PH_ST_B;
              end
              i2cm_pkg::PH_ST_B: begin
                scl_reg_next = 1'b0;
                done         = 1'b1;
                phase_next   = i2cm_pkg::PH_IDLE;
              end
              i2cm_pkg::PH_SP_A: begin
                scl_reg_next = 1'b1;
                sda_reg_next = 1'b1;
                phase_next   = i2cm_pkg::PH_SP_B;
              end
              default: begin
                done       = 1'b1;
                phase_next = i2cm_pkg::PH_IDLE;
              end
            endcase
          end
        end
        i2cm_pkg::PH_WR_SETUP: begin
          if (unit_tick) begin
            scl_reg_next = 1'b1;
            phase_next   = i2cm_pkg::PH_WR_HIGH;
          end
        end
        i2cm_pkg::PH_WR_HIGH: begin
          if (unit_tick) begin
            scl_reg_next = 1'b0;
            phase_next   = i2cm_pkg::PH_WR_LOW;
          end
        end
        i2cm_pkg::PH_WR_LOW: begin
          if (unit_tick) begin
            bit_count_next = bit_inc;
            if (bit_inc < 4'd8) begin
              sda_reg_next = tx_shift[7];
              phase_next   = i2cm_pkg::PH_WR_SETUP;
            end else begin
              sda_oe_reg_next = 1'b0;
              sda_reg_next    = 1'b1;
              phase_next      = i2cm_pkg::PH_WA_REL;
            end
          end
        end
        i2cm_pkg::PH_WA_REL: begin
          if (unit_tick) begin
            scl_reg_next    = 1'b1;
            unit_count_next = '0;
            phase_next      = i2cm_pkg::PH_WA_POLL;
          end
        end
        i2cm_pkg::PH_WA_POLL: begin
          if (unit_tick) begin
            priority if (!req.sda_sample) begin
              scl_reg_next   = 1'b0;
              fail_flag_next = 1'b0;
              done           = 1'b1;
              phase_next     = i2cm_pkg::PH_IDLE;
            end else if (unit_count >= cfg.ack_timeout_units) begin
              fail_flag_next  = 1'b1;
              sda_oe_reg_next = 1'b1;
              scl_reg_next    = 1'b0;
              sda_reg_next    = 1'b0;
              unit_count_next = '0;
              phase_next      = i2cm_pkg::PH_SP_A;
            end else begin
              unit_count_next = unit_inc;
            end
          end
        end
        i2cm_pkg::PH_RD_LOW: begin
          if (unit_tick) begin
            scl_reg_next    = 1'b1;
            shift_byte_next = {shift_byte[6:0], req.sda_sample};
            phase_next      = i2cm_pkg::PH_RD_HIGH;
          end
        end
        i2cm_pkg::PH_RD_HIGH: begin
          if (unit_tick) begin
            bit_count_next = bit_inc;
            scl_reg_next   = 1'b0;
            if (bit_inc < 4'd8) begin
              phase_next = i2cm_pkg::PH_RD_LOW;
            end else begin
              sda_oe_reg_next = 1'b1;
              sda_reg_next    = !ack_bit;
              phase_next      = i2cm_pkg::PH_AK_SETUP;
            end
          end
        end
        i2cm_pkg::PH_AK_SETUP: begin
          if (unit_tick) begin
            scl_reg_next = 1'b1;
            phase_next   = i2cm_pkg::PH_AK_HIGH;
          end
        end
        i2cm_pkg::PH_AK_HIGH: begin
          if (unit_tick) begin
            scl_reg_next = 1'b0;
            rx_reg_next  = shift_byte;
            done         = 1'b1;
            phase_next   = i2cm_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_level        = scl_reg_next;
    res.sda_level        = sda_reg_next;
    res.sda_drive_enable = sda_oe_reg_next;
    res.busy_res         = (phase_next != i2cm_pkg::PH_IDLE);
    res.done_res         = done;
    res.rx_byte          = rx_reg_next;
    res.ack_failed       = fail_flag_next;
    res.command_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cm_pkg::PH_IDLE;
      bit_count  <= '0;
      shift_byte <= '0;
      tick_count <= '0;
      unit_count <= '0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_oe_reg <= 1'b1;
      ack_bit    <= 1'b0;
      fail_flag  <= 1'b0;
      rx_reg     <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      tick_count <= tick_count_next;
      unit_count <= unit_count_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_oe_reg <= sda_oe_reg_next;
      ack_bit    <= ack_bit_next;
      fail_flag  <= fail_flag_next;
      rx_reg     <= rx_reg_next;
    end
  end

  a_idle_never_rejects: assert property (@(posedge clk) disable iff (rst)
    step && phase == i2cm_pkg::PH_IDLE |-> !rejected)
    else $error("A request taken while idle was flagged as rejected.");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    step && done |-> phase_next == i2cm_pkg::PH_IDLE)
    else $error("A completing request left the engine busy.");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_count) && $stable(unit_count))
    else $error("Engine state moved without a request being taken.");

  a_bit_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("Bit counter ran past one byte.");

endmodule

/* rtl/i2c_master_byte_engine.sv */
// A request accepted into the request queue is stepped by the engine combinationally, and its result is
// registered into the result queue, from which it can be popped; a full result queue stalls the step.
// Throughput: one request per cycle while the result queue has room; the bus engine steps once per request.
// The request queue and the result queue each hold QUEUE_DEPTH entries.
// Reset: synchronous; both queues empty, the engine idle with SCL and SDA driven high,
// and the registers back at 100 ticks per unit, 4 start/stop units and 50 timeout units.
// ----------------------------------------------------------------------------
// I2C master byte engine top level
// Configuration registers, request front end, bus engine and result queue.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic        sda_sample,
  output logic        empty,
  input  logic        pop,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive_enable,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_failed,
  output logic        command_rejected
);

  i2cm_pkg::cfg_t cfg;
  i2cm_pkg::req_t req;
  i2cm_pkg::res_t res_in;
  i2cm_pkg::res_t res_out;
  logic           req_empty;
  logic           req_pop;
  logic           res_push;
  logic           res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_unit    <= i2cm_pkg::TICKS_PER_UNIT_RESET;
      cfg.start_stop_units  <= i2cm_pkg::START_STOP_UNITS_RESET;
      cfg.ack_timeout_units <= i2cm_pkg::ACK_TIMEOUT_UNITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        i2cm_pkg::REG_TICKS_PER_UNIT:    cfg.ticks_per_unit    <= cfg_data;
        i2cm_pkg::REG_START_STOP_UNITS:  cfg.start_stop_units  <= cfg_data[3:0];
        i2cm_pkg::REG_ACK_TIMEOUT_UNITS: cfg.ack_timeout_units <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_sample (sda_sample),
    .req_pop    (req_pop),
    .req        (req),
    .req_empty  (req_empty)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  i2cm_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (i2cm_pkg::res_t)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_out),
    .empty     (empty)
  );

  assign scl_level        = res_out.scl_level;
  assign sda_level        = res_out.sda_level;
  assign sda_drive_enable = res_out.sda_drive_enable;
  assign busy_res         = res_out.busy_res;
  assign done_res         = res_out.done_res;
  assign rx_byte          = res_out.rx_byte;
  assign ack_failed       = res_out.ack_failed;
  assign command_rejected = res_out.command_rejected;

endmodule
